FILE: hdl/ewp_pkg.sv
// ewp_pkg: shared types, codes and constants of the equal work partitioner
// no dependencies; imported by the interfaces and every module of the block

package ewp_pkg;

  // field widths
  localparam int unsigned TotalW   = 64;
  localparam int unsigned PartsW   = 8;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned WorkersW = 32;
  localparam int unsigned HistW    = 64;
  localparam int unsigned ErrW     = 3;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 64;

  // default upper bound on parts per request
  localparam int unsigned MAX_PARTS_DFLT = 64;

  // command queue between front and back
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CmdPtrW   = $clog2(CMD_DEPTH);

  // error codes
  localparam logic [ErrW-1:0] ERR_NONE       = 3'd0;
  localparam logic [ErrW-1:0] ERR_ZERO_TOTAL = 3'd1;
  localparam logic [ErrW-1:0] ERR_ZERO_PARTS = 3'd2;
  localparam logic [ErrW-1:0] ERR_ZERO_WORK  = 3'd3;
  localparam logic [ErrW-1:0] ERR_MANY_PARTS = 3'd4;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_WORKERS = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_HISTORY = 8'd1;

  // register reset values
  localparam logic [WorkersW-1:0] WORKERS_RST = 32'd1;
  localparam logic [HistW-1:0]    HISTORY_RST = 64'd0;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [WorkersW-1:0] workers;
    logic [HistW-1:0]    history;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [TotalW-1:0] quot;
    logic [PartsW-1:0] rem;
    logic [PartsW-1:0] parts;
    logic [ErrW-1:0]   err;
  } cmd_t;

endpackage

FILE: hdl/ewp_intf.sv
// ewp_intf: valid/ready channel interfaces of the equal work partitioner
// depends on ewp_pkg for field widths

// request channel
interface ewp_in_if import ewp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TotalW-1:0] total_count;
  logic [PartsW-1:0] part_count;

  modport source (output valid, total_count, part_count, input ready);
  modport sink   (input valid, total_count, part_count, output ready);
endinterface

// result channel
interface ewp_out_if import ewp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IdxW-1:0]     part_index;
  logic [TotalW-1:0]   part_size;
  logic [TotalW-1:0]   start_offset;
  logic [WorkersW-1:0] part_workers;
  logic [HistW-1:0]    base_history;
  logic                last;
  logic [ErrW-1:0]     error_code;

  modport source (output valid, part_index, part_size, start_offset, part_workers,
                  base_history, last, error_code, input ready);
  modport sink   (input valid, part_index, part_size, start_offset, part_workers,
                  base_history, last, error_code, output ready);
endinterface

// register write channel
interface ewp_cfg_if import ewp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/ewp_front.sv
// ewp_front: accepts requests, checks them and runs the bit-serial divider
// depends on ewp_pkg and ewp_in_if; feeds ewp_cmd_fifo

module ewp_front import ewp_pkg::*; #(
  parameter int unsigned MaxParts = MAX_PARTS_DFLT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ewp_in_if.sink       in_i,
  input  cfg_t         cfg_i,
  output cmd_t         cmd_o,
  output logic         cmd_valid_o,
  input  logic         cmd_ready_i
);

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_DIV  = 2'd1;
  localparam logic [1:0] FS_PUSH = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [IdxW-1:0]   step_q, step_d;
  logic [TotalW-1:0] dvd_q, dvd_d;
  logic [PartsW-1:0] rem_q, rem_d;
  logic [PartsW-1:0] div_q, div_d;
  logic [ErrW-1:0]   err_q, err_d;

  logic              accept;
  logic [ErrW-1:0]   err_in;
  logic [PartsW:0]   rem_sh;
  logic [PartsW:0]   rem_sub;
  logic              rem_ge;

  assign in_i.ready = (state_q == FS_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // request checks, first match wins
  always_comb begin
    priority if (in_i.total_count == '0) begin
      err_in = ERR_ZERO_TOTAL;
    end else if (in_i.part_count == '0) begin
      err_in = ERR_ZERO_PARTS;
    end else if (cfg_i.workers == '0) begin
      err_in = ERR_ZERO_WORK;
    end else if (in_i.part_count > PartsW'(MaxParts)) begin
      err_in = ERR_MANY_PARTS;
    end else begin
      err_in = ERR_NONE;
    end
  end

  // one restoring division step: quotient bits shift in behind the dividend
  assign rem_sh  = {rem_q, dvd_q[TotalW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, div_q});
  assign rem_sub = rem_sh - {1'b0, div_q};

  // sequencer and datapath next values
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    div_d   = div_q;
    err_d   = err_q;
    unique case (state_q)
      FS_IDLE: begin
        if (accept) begin
          dvd_d   = in_i.total_count;
          rem_d   = '0;
          div_d   = in_i.part_count;
          err_d   = err_in;
          step_d  = '0;
          state_d = (err_in == ERR_NONE) ? FS_DIV : FS_PUSH;
        end
      end
      FS_DIV: begin
        dvd_d  = {dvd_q[TotalW-2:0], rem_ge};
        rem_d  = rem_ge ? rem_sub[PartsW-1:0] : rem_sh[PartsW-1:0];
        step_d = step_q + 1'b1;
        if (step_q == '1) begin
          state_d = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (cmd_ready_i) begin
          state_d = FS_IDLE;
        end
      end
      default: begin
        state_d = FS_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
    err_q <= err_d;
  end

  // command to the queue
  assign cmd_valid_o = (state_q == FS_PUSH);
  assign cmd_o.quot  = dvd_q;
  assign cmd_o.rem   = rem_q;
  assign cmd_o.parts = div_q;
  assign cmd_o.err   = err_q;

endmodule

FILE: hdl/ewp_cmd_fifo.sv
// ewp_cmd_fifo: short command queue between the front and the back
// depends on ewp_pkg for cmd_t and the queue depth

module ewp_cmd_fifo import ewp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t wr_cmd_i,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  output cmd_t rd_cmd_o,
  output logic rd_valid_o,
  input  logic rd_ready_i
);

  cmd_t               mem_q [CMD_DEPTH];
  logic [CmdPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CmdPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CmdPtrW:0]   cnt_q, cnt_d;
  logic               push, pop;

  assign wr_ready_o = (cnt_q != (CmdPtrW+1)'(CMD_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_cmd_o   = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == CmdPtrW'(CMD_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == CmdPtrW'(CMD_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

FILE: hdl/ewp_back.sv
// ewp_back: walks the parts of one command and drives the result register
// depends on ewp_pkg and ewp_out_if; fed by ewp_cmd_fifo

module ewp_back import ewp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cfg_t        cfg_i,
  ewp_out_if.source   out_o
);

  logic                active_q, active_d;
  cmd_t                cur_q;
  logic [IdxW-1:0]     idx_q;
  logic [TotalW-1:0]   offset_q;

  logic                out_valid_q, out_valid_d;
  logic [IdxW-1:0]     out_idx_q;
  logic [TotalW-1:0]   out_size_q;
  logic [TotalW-1:0]   out_start_q;
  logic [WorkersW-1:0] out_workers_q;
  logic [HistW-1:0]    out_hist_q;
  logic                out_last_q;
  logic [ErrW-1:0]     out_err_q;

  logic                take;
  logic                emit;
  logic                is_err;
  logic                is_last;
  logic [TotalW-1:0]   size;
  logic [PartsW-1:0]   idx_ext;

  assign cmd_ready_o = !active_q;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign emit        = active_q && (!out_valid_q || out_o.ready);

  // size and last flag of the current part
  assign idx_ext = {{(PartsW-IdxW){1'b0}}, idx_q};
  assign is_err  = (cur_q.err != ERR_NONE);
  assign size    = cur_q.quot + {{(TotalW-1){1'b0}}, (idx_ext < cur_q.rem)};
  assign is_last = is_err || ((idx_ext + 1'b1) == cur_q.parts);

  always_comb begin
    active_d = active_q;
    if (take) begin
      active_d = 1'b1;
    end else if (emit && is_last) begin
      active_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // part walk: index and running offset
  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q    <= cmd_i;
      idx_q    <= '0;
      offset_q <= '0;
    end else if (emit) begin
      idx_q    <= idx_q + 1'b1;
      offset_q <= offset_q + size;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_idx_q     <= is_err ? '0 : idx_q;
      out_size_q    <= is_err ? '0 : size;
      out_start_q   <= is_err ? '0 : offset_q;
      out_workers_q <= cfg_i.workers;
      out_hist_q    <= cfg_i.history;
      out_last_q    <= is_last;
      out_err_q     <= cur_q.err;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.part_index   = out_idx_q;
  assign out_o.part_size    = out_size_q;
  assign out_o.start_offset = out_start_q;
  assign out_o.part_workers = out_workers_q;
  assign out_o.base_history = out_hist_q;
  assign out_o.last         = out_last_q;
  assign out_o.error_code   = out_err_q;

endmodule

FILE: hdl/equal_work_partitioner.sv
// equal_work_partitioner: top level, register file and front/queue/back wiring
// depends on ewp_pkg, ewp_intf, ewp_front, ewp_cmd_fifo and ewp_back
//
//   channel  dir  beat carries
//   cfg_i    in   index, data (register write, always ready)
//   in_i     in   total_count, part_count
//   out_o    out  part_index, part_size, start_offset, part_workers,
//                 base_history, last, error_code
//
// in the front a request is accepted, runs through the bit-serial 64-bit divider
// and is pushed into the command queue; a request with an error skips the divider;
// the back loads a command and then puts out one result beat per cycle while the
// output is not stalled; the front takes a new request once its command is queued
// reset clears control state only, registers return to workers 1, history 0;
// no clearing pass; a stalled output holds the back; the front fills the queue

module equal_work_partitioner import ewp_pkg::*; #(
  parameter int unsigned MAX_PARTS = MAX_PARTS_DFLT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ewp_cfg_if.sink   cfg_i,
  ewp_in_if.sink    in_i,
  ewp_out_if.source out_o
);

  logic [WorkersW-1:0] workers_q;
  logic [HistW-1:0]    history_q;
  cfg_t                cfg;
  logic                cfg_wr;

  cmd_t fr_cmd, bk_cmd;
  logic fr_valid, fr_ready;
  logic bk_valid, bk_ready;

  // register writes, unknown indexes ignored
  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      workers_q <= WORKERS_RST;
      history_q <= HISTORY_RST;
    end else if (cfg_wr) begin
      if (cfg_i.index == REG_WORKERS) begin
        workers_q <= cfg_i.data[WorkersW-1:0];
      end else if (cfg_i.index == REG_HISTORY) begin
        history_q <= cfg_i.data[HistW-1:0];
      end
    end
  end

  assign cfg.workers = workers_q;
  assign cfg.history = history_q;

  ewp_front #(
    .MaxParts (MAX_PARTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg),
    .cmd_o       (fr_cmd),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready)
  );

  ewp_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_cmd_i   (fr_cmd),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .rd_cmd_o   (bk_cmd),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready)
  );

  ewp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (bk_cmd),
    .cmd_valid_i (bk_valid),
    .cmd_ready_o (bk_ready),
    .cfg_i       (cfg),
    .out_o       (out_o)
  );

endmodule
